// ----- design/pcm8_ldr_pkg.sv -----
// Package: shared types, constants and codes for the PCM8 lump decode resampler.
package pcm8_ldr_pkg;

  // Header and validation constants
  localparam logic [3:0]  HDR_BYTES    = 4'd8;
  localparam logic [15:0] PCM_FORMAT   = 16'd3;
  localparam logic [15:0] RATE_MIN     = 16'd2000;
  localparam logic [15:0] RATE_MAX     = 16'd64000;
  localparam logic [15:0] TARGET_RESET = 16'd22050;
  localparam logic [7:0]  SAMPLE_BIAS  = 8'h80;

  // Run limits per input byte (sample items only)
  localparam logic [5:0] MAX_RUN      = 6'd33;
  localparam logic [5:0] MAX_RUN_LAST = 6'd32;

  // Command queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Phase arithmetic widths
  localparam int PH_W  = 17;
  localparam int ACC_W = 19;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_FORMAT = 2'd2,
    ST_META   = 2'd3
  } status_t;

  // One classified byte handed from front to back
  typedef struct packed {
    logic [7:0]  byte_value;
    logic        has_sample;
    logic        last_smp;
    logic        has_end;
    status_t     status;
    logic [15:0] src_rate;
  } lump_cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_STAT
  } bk_state_t;

endpackage

// ----- design/pcm8_lump_decode_resample_unit.sv -----
// Top level: 8-bit PCM lump decoder with nearest-neighbor resampling to 16-bit samples.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------------
//  input   | in_valid / in_stall  | byte_value, end_of_lump
//  output  | out_valid / out_stall| sample_value, sample_valid, end_of_sound, status_code,
//          |                      | run_last
//  config  | cfg_valid / cfg_ready| target_rate
//
// Header bytes and silent bytes are absorbed in the front end and push no command. A sample
// byte is loaded by the back end, then emits its output samples, and then closes the run;
// the end byte adds a status item, plus a load step if it has no sample.
// The repeat sequencer in the back end emitting one item per cycle sets the rate, as long
// as out_stall does not hold the output register.
// Reset is synchronous; target_rate returns to 22050 and all lump state clears.
// in_stall rises when the 4-entry command queue is full; out_stall holds the output register.
module pcm8_lump_decode_resample_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_value,
  input  logic               end_of_lump,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_value,
  output logic               sample_valid,
  output logic               end_of_sound,
  output logic [1:0]         status_code,
  output logic               run_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        target_rate
);
  import pcm8_ldr_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  lump_cmd_t push_cmd;
  lump_cmd_t head_cmd;

  // Accept bytes while the queue has room
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  pcm8_ldr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (byte_value),
    .end_of_lump(end_of_lump),
    .push       (push),
    .cmd        (push_cmd)
  );

  pcm8_ldr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  pcm8_ldr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_rate    (target_rate),
    .head_cmd    (head_cmd),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_value(sample_value),
    .sample_valid(sample_valid),
    .end_of_sound(end_of_sound),
    .status_code (status_code),
    .run_last    (run_last)
  );

endmodule

// ----- design/pcm8_ldr_front.sv -----
// Front end: header parsing, byte classification and command generation.
module pcm8_ldr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             byte_value,
  input  logic                   end_of_lump,
  output logic                   push,
  output pcm8_ldr_pkg::lump_cmd_t cmd
);
  import pcm8_ldr_pkg::*;

  logic [3:0]  hdr_pos, hdr_pos_next;
  logic [15:0] fmt_word, fmt_word_next;
  logic [15:0] src_rate, src_rate_next;
  logic [31:0] decl_cnt, decl_cnt_next;
  logic [31:0] consumed, consumed_next;
  status_t     err, err_next;

  logic        in_hdr;
  logic        is_sample;
  status_t     end_status;

  // Classify the byte and build the next lump state
  always_comb begin
    fmt_word_next = fmt_word;
    src_rate_next = src_rate;
    decl_cnt_next = decl_cnt;
    hdr_pos_next  = hdr_pos;
    err_next      = err;
    in_hdr        = (hdr_pos < HDR_BYTES);
    if (in_hdr) begin
      unique case (hdr_pos[2:0])
        3'd0: fmt_word_next[7:0]   = byte_value;
        3'd1: fmt_word_next[15:8]  = byte_value;
        3'd2: src_rate_next[7:0]   = byte_value;
        3'd3: src_rate_next[15:8]  = byte_value;
        3'd4: decl_cnt_next[7:0]   = byte_value;
        3'd5: decl_cnt_next[15:8]  = byte_value;
        3'd6: decl_cnt_next[23:16] = byte_value;
        3'd7: decl_cnt_next[31:24] = byte_value;
        default: ;
      endcase
      hdr_pos_next = hdr_pos + 4'd1;
      if (hdr_pos_next == HDR_BYTES) begin
        if (fmt_word_next != PCM_FORMAT) begin
          err_next = ST_FORMAT;
        end else if (src_rate_next < RATE_MIN || src_rate_next > RATE_MAX ||
                     decl_cnt_next == 32'd0) begin
          err_next = ST_META;
        end else begin
          err_next = ST_OK;
        end
      end
    end
    is_sample     = !in_hdr && (err == ST_OK) && (consumed < decl_cnt);
    consumed_next = consumed + {31'd0, is_sample};

    // Verdict reported on the end byte
    if (hdr_pos_next < HDR_BYTES) begin
      end_status = ST_SHORT;
    end else if (err_next != ST_OK) begin
      end_status = err_next;
    end else if (consumed_next == 32'd0) begin
      end_status = ST_META;
    end else begin
      end_status = ST_OK;
    end
  end

  // Drive the command toward the queue
  always_comb begin
    cmd.byte_value = byte_value;
    cmd.has_sample = is_sample;
    cmd.last_smp   = end_of_lump || (consumed + 32'd1 == decl_cnt);
    cmd.has_end    = end_of_lump;
    cmd.status     = end_status;
    cmd.src_rate   = src_rate;
    push           = accept && (is_sample || end_of_lump);
  end

  // Advance lump state on each accepted item; clear at lump end
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos  <= '0;
      fmt_word <= '0;
      src_rate <= '0;
      decl_cnt <= '0;
      consumed <= '0;
      err      <= ST_OK;
    end else if (accept) begin
      if (end_of_lump) begin
        hdr_pos  <= '0;
        fmt_word <= '0;
        src_rate <= '0;
        decl_cnt <= '0;
        consumed <= '0;
        err      <= ST_OK;
      end else begin
        hdr_pos  <= hdr_pos_next;
        fmt_word <= fmt_word_next;
        src_rate <= src_rate_next;
        decl_cnt <= decl_cnt_next;
        consumed <= consumed_next;
        err      <= err_next;
      end
    end
  end

endmodule

// ----- design/pcm8_ldr_queue.sv -----
// Command queue: short register FIFO between front and back.
module pcm8_ldr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pcm8_ldr_pkg::lump_cmd_t push_cmd,
  input  logic                    pop,
  output pcm8_ldr_pkg::lump_cmd_t head_cmd,
  output logic                    full,
  output logic                    empty
);
  import pcm8_ldr_pkg::*;

  lump_cmd_t      slots [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   count;

  assign full     = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = slots[rptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- design/pcm8_ldr_back.sv -----
// Back end: nearest-neighbor repeat sequencer, status emission and output register.
module pcm8_ldr_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [15:0]             cfg_rate,
  input  pcm8_ldr_pkg::lump_cmd_t head_cmd,
  input  logic                    q_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [15:0]      sample_value,
  output logic                    sample_valid,
  output logic                    end_of_sound,
  output logic [1:0]              status_code,
  output logic                    run_last
);
  import pcm8_ldr_pkg::*;

  bk_state_t        state, state_next;
  lump_cmd_t        cmd;
  logic [15:0]      rate_target;
  logic [PH_W-1:0]  phase, phase_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [ACC_W-1:0] nxt, nxt_next;
  logic [5:0]       run_cnt, run_cnt_next;

  logic [ACC_W-1:0] t_ext, s_ext, nxt2;
  logic [5:0]       run_cnt1;
  logic             cond_now, cond_next;
  logic             out_free;
  logic             emit_smp, emit_stat;
  logic             load;

  assign out_free = !out_valid || !out_stall;
  assign t_ext    = {3'b000, rate_target};
  assign s_ext    = {3'b000, cmd.src_rate};
  assign nxt2     = nxt + s_ext;
  assign run_cnt1 = run_cnt + 6'd1;

  // Evaluate whether this output index and the following one are emitted
  always_comb begin
    priority if (rate_target == 16'd0) begin
      cond_now  = (run_cnt == 6'd0);
      cond_next = 1'b0;
    end else if (cmd.last_smp) begin
      cond_now  = (nxt <= t_ext) && (run_cnt < MAX_RUN_LAST);
      cond_next = (nxt2 <= t_ext) && (run_cnt1 < MAX_RUN_LAST);
    end else begin
      cond_now  = (acc < t_ext) && (run_cnt < MAX_RUN);
      cond_next = (nxt < t_ext) && (run_cnt1 < MAX_RUN);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = head_cmd.has_sample ? BK_RUN : BK_STAT;
        end
      end
      BK_RUN: begin
        if (!cond_now) begin
          state_next = cmd.has_end ? BK_STAT : BK_IDLE;
        end
      end
      BK_STAT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath controls and next values
  always_comb begin
    load         = 1'b0;
    emit_smp     = 1'b0;
    emit_stat    = 1'b0;
    acc_next     = acc;
    nxt_next     = nxt;
    run_cnt_next = run_cnt;
    phase_next   = phase;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          load         = 1'b1;
          acc_next     = {2'b00, phase};
          nxt_next     = {2'b00, phase} + {3'b000, head_cmd.src_rate};
          run_cnt_next = 6'd0;
        end
      end
      BK_RUN: begin
        if (cond_now) begin
          if (out_free) begin
            emit_smp     = 1'b1;
            acc_next     = nxt;
            nxt_next     = nxt2;
            run_cnt_next = run_cnt1;
          end
        end else if (rate_target == 16'd0) begin
          phase_next = phase;
        end else if (cmd.last_smp) begin
          phase_next = '0;
        end else if (acc >= t_ext) begin
          phase_next = PH_W'(acc - t_ext);
        end else begin
          phase_next = PH_W'(acc);
        end
      end
      BK_STAT: begin
        if (out_free) begin
          emit_stat  = 1'b1;
          phase_next = '0;
        end
      end
      default: ;
    endcase
    pop = load;
  end

  // Hold sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      phase       <= '0;
      rate_target <= TARGET_RESET;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cfg_write) begin
        rate_target <= cfg_rate;
      end
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= head_cmd;
    end
    acc     <= acc_next;
    nxt     <= nxt_next;
    run_cnt <= run_cnt_next;
  end

  // Output register: load a new item whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit_smp || emit_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (emit_smp) begin
        sample_value <= {cmd.byte_value ^ SAMPLE_BIAS, 8'h00};
        sample_valid <= 1'b1;
        end_of_sound <= 1'b0;
        status_code  <= ST_OK;
        run_last     <= !cmd.has_end && !cond_next;
      end else if (emit_stat) begin
        sample_value <= '0;
        sample_valid <= 1'b0;
        end_of_sound <= 1'b1;
        status_code  <= cmd.status;
        run_last     <= 1'b1;
      end
    end
  end

  a_status_closes_run: assert property (@(posedge clk) disable iff (rst)
                                        (out_valid && end_of_sound) |-> (run_last && !sample_valid))
    else $error("status item must close its run");
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
                                (state == BK_RUN) |-> (run_cnt <= MAX_RUN))
    else $error("run count beyond limit");
  a_stat_needs_end: assert property (@(posedge clk) disable iff (rst)
                                     (state == BK_STAT) |-> cmd.has_end)
    else $error("status state without lump end");

endmodule
